// ===== design/kleb_pkg.sv =====
// kleb_pkg: shared types and key codes for the keystroke line edit buffer
// used by kleb_key_decode and keystroke_line_edit_buffer_unit; no dependencies

package kleb_pkg;

    // operation codes of an input transaction
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // key codes
    localparam logic [7:0] KEY_BS       = 8'd8;
    localparam logic [7:0] KEY_TAB      = 8'd9;
    localparam logic [7:0] KEY_LF       = 8'd10;
    localparam logic [7:0] KEY_CR       = 8'd13;
    localparam logic [7:0] KEY_ESC      = 8'd27;
    localparam logic [7:0] KEY_PRINT_LO = 8'd32;
    localparam logic [7:0] KEY_LBRACKET = 8'd91;
    localparam logic [7:0] KEY_UP_C     = 8'd67;
    localparam logic [7:0] KEY_UP_D     = 8'd68;
    localparam logic [7:0] KEY_PRINT_HI = 8'd126;
    localparam logic [7:0] KEY_DEL      = 8'd127;

    // escape sequence progress
    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } t_esc;

    // edit action chosen for one transaction
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_DELETE,
        ACT_LEFT,
        ACT_RIGHT,
        ACT_READ,
        ACT_CLEAR
    } t_act;

    // decoded command handed from the decoder to the sequencer
    typedef struct packed {
        t_act       act;
        logic [7:0] ins_char;
        logic       enter;
        t_esc       esc_next;
    } t_key_cmd;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_READ,
        S_RESP
    } t_state;

endpackage

// ===== design/kleb_key_decode.sv =====
// kleb_key_decode: turns op, key byte and escape progress into an edit command
// depends on kleb_pkg

module kleb_key_decode (
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_key_byte,
    input  kleb_pkg::t_esc      i_esc,
    output kleb_pkg::t_key_cmd  o_cmd
);

    always_comb begin
        o_cmd          = '0;
        o_cmd.act      = kleb_pkg::ACT_NONE;
        o_cmd.ins_char = i_key_byte;
        o_cmd.enter    = 1'b0;
        o_cmd.esc_next = i_esc;
        case (i_op)
            kleb_pkg::OP_KEY: begin
                case (i_esc)
                    // second byte of an escape sequence
                    kleb_pkg::ESC_SEEN: begin
                        o_cmd.esc_next = (i_key_byte == kleb_pkg::KEY_LBRACKET) ?
                                         kleb_pkg::ESC_BRACKET : kleb_pkg::ESC_NONE;
                    end
                    // third byte: arrow keys, anything else is swallowed
                    kleb_pkg::ESC_BRACKET: begin
                        o_cmd.esc_next = kleb_pkg::ESC_NONE;
                        if (i_key_byte == kleb_pkg::KEY_UP_D) begin
                            o_cmd.act = kleb_pkg::ACT_LEFT;
                        end else if (i_key_byte == kleb_pkg::KEY_UP_C) begin
                            o_cmd.act = kleb_pkg::ACT_RIGHT;
                        end
                    end
                    default: begin
                        o_cmd.esc_next = kleb_pkg::ESC_NONE;
                        if (i_key_byte == kleb_pkg::KEY_TAB) begin
                            o_cmd.act      = kleb_pkg::ACT_INSERT;
                            o_cmd.ins_char = kleb_pkg::KEY_LF;
                        end else if (i_key_byte inside {kleb_pkg::KEY_LF, kleb_pkg::KEY_CR}) begin
                            o_cmd.enter = 1'b1;
                        end else if (i_key_byte == kleb_pkg::KEY_ESC) begin
                            o_cmd.esc_next = kleb_pkg::ESC_SEEN;
                        end else if (i_key_byte inside {kleb_pkg::KEY_DEL, kleb_pkg::KEY_BS}) begin
                            o_cmd.act = kleb_pkg::ACT_DELETE;
                        end else if (i_key_byte inside
                                     {[kleb_pkg::KEY_PRINT_LO:kleb_pkg::KEY_PRINT_HI]}) begin
                            o_cmd.act = kleb_pkg::ACT_INSERT;
                        end
                    end
                endcase
            end
            kleb_pkg::OP_READ: begin
                o_cmd.act = kleb_pkg::ACT_READ;
            end
            kleb_pkg::OP_CLEAR: begin
                o_cmd.act      = kleb_pkg::ACT_CLEAR;
                o_cmd.esc_next = kleb_pkg::ESC_NONE;
            end
            default: begin
                o_cmd.act = kleb_pkg::ACT_NONE;
            end
        endcase
    end

endmodule

// ===== design/keystroke_line_edit_buffer_unit.sv =====
// keystroke_line_edit_buffer_unit: line edit buffer with cursor, text memory and sequencer
// depends on kleb_pkg and kleb_key_decode
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall  | i_op, i_key_byte, i_read_index
//  output  | out       | o_valid / i_stall  | o_read_char, o_text_length,
//          |           |                    | o_cursor_position, o_enter_seen, o_overflow
//
// one transaction at a time; the text memory has one write and one read port, so
// insert and delete move one character per pass through a read state and a write
// state (S_INS_RD then S_INS_WR, S_DEL_RD then S_DEL_WR); a read below the length
// passes through S_READ, and every transaction ends in S_RESP.
// reset clears length, cursor and escape progress; text memory contents are not cleared.
// a result waiting under i_stall holds the sequencer in its response state.

module keystroke_line_edit_buffer_unit #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_key_byte,
    input  logic [7:0] i_read_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_char,
    output logic [8:0] o_text_length,
    output logic [8:0] o_cursor_position,
    output logic       o_enter_seen,
    output logic       o_overflow
);

    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = (LW > 8) ? LW : 8;
    localparam int OW = (LW > 9) ? LW : 9;
    localparam logic [LW-1:0] LEN_FULL = LW'(BUFFER_DEPTH);
    localparam logic [LW-1:0] ONE      = LW'(1);

    kleb_pkg::t_state   r_state, n_state;
    kleb_pkg::t_esc     r_esc, n_esc;
    kleb_pkg::t_key_cmd w_cmd;

    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_cursor, n_cursor;
    logic [LW-1:0] r_ptr, n_ptr;
    logic [7:0]    r_char, n_char;
    logic [7:0]    r_rd, n_rd;
    logic          r_enter, n_enter;
    logic          r_ovf, n_ovf;
    logic          r_o_valid, n_o_valid;
    logic          w_load;

    // text memory, one write and one registered read per cycle
    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata;

    // shared pointer step and compare unit
    logic [LW-1:0] w_ptr_dec, w_ptr_inc, w_cmp_a, w_cmp_b;
    logic          w_cmp_lt;
    logic [CW-1:0] w_idx_ext, w_len_ext;
    logic [OW-1:0] w_len_out, w_cur_out;

    kleb_key_decode u_decode (
        .i_op       (i_op),
        .i_key_byte (i_key_byte),
        .i_esc      (r_esc),
        .o_cmd      (w_cmd)
    );

    assign w_ptr_dec = r_ptr - ONE;
    assign w_ptr_inc = r_ptr + ONE;
    assign w_cmp_lt  = w_cmp_a < w_cmp_b;
    assign w_idx_ext = CW'(i_read_index);
    assign w_len_ext = CW'(r_len);
    assign w_len_out = OW'(r_len);
    assign w_cur_out = OW'(r_cursor);

    assign o_stall = (r_state != kleb_pkg::S_IDLE);
    assign o_valid = r_o_valid;

    // compare operands follow the loop being run
    always_comb begin
        case (r_state)
            kleb_pkg::S_DEL_RD: begin
                w_cmp_a = w_ptr_inc;
                w_cmp_b = r_len;
            end
            default: begin
                w_cmp_a = r_cursor;
                w_cmp_b = r_ptr;
            end
        endcase
    end

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_esc     = r_esc;
        n_len     = r_len;
        n_cursor  = r_cursor;
        n_ptr     = r_ptr;
        n_char    = r_char;
        n_rd      = r_rd;
        n_enter   = r_enter;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid;
        w_load    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_ptr[AW-1:0];
        w_wdata   = r_rdata;
        w_raddr   = w_ptr_dec[AW-1:0];

        // taken result frees the output register
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            kleb_pkg::S_IDLE: begin
                w_raddr = w_idx_ext[AW-1:0];
                if (i_valid) begin
                    n_esc   = w_cmd.esc_next;
                    n_rd    = 8'd0;
                    n_enter = w_cmd.enter;
                    n_ovf   = 1'b0;
                    n_char  = w_cmd.ins_char;
                    n_state = kleb_pkg::S_RESP;
                    case (w_cmd.act)
                        kleb_pkg::ACT_INSERT: begin
                            if (r_len == LEN_FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_ptr   = r_len;
                                n_state = kleb_pkg::S_INS_RD;
                            end
                        end
                        kleb_pkg::ACT_DELETE: begin
                            if (r_cursor != '0) begin
                                n_ptr   = r_cursor - ONE;
                                n_state = kleb_pkg::S_DEL_RD;
                            end
                        end
                        kleb_pkg::ACT_LEFT: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - ONE;
                            end
                        end
                        kleb_pkg::ACT_RIGHT: begin
                            if (r_cursor < r_len) begin
                                n_cursor = r_cursor + ONE;
                            end
                        end
                        kleb_pkg::ACT_READ: begin
                            if (w_idx_ext < w_len_ext) begin
                                n_state = kleb_pkg::S_READ;
                            end
                        end
                        kleb_pkg::ACT_CLEAR: begin
                            n_len    = '0;
                            n_cursor = '0;
                        end
                        default: begin
                            n_state = kleb_pkg::S_RESP;
                        end
                    endcase
                end
            end
            // insert: fetch the character left of the pointer, or drop in the new one
            kleb_pkg::S_INS_RD: begin
                if (w_cmp_lt) begin
                    n_state = kleb_pkg::S_INS_WR;
                end else begin
                    w_we     = 1'b1;
                    w_waddr  = r_cursor[AW-1:0];
                    w_wdata  = r_char;
                    n_cursor = r_cursor + ONE;
                    n_len    = r_len + ONE;
                    n_state  = kleb_pkg::S_RESP;
                end
            end
            kleb_pkg::S_INS_WR: begin
                w_we    = 1'b1;
                n_ptr   = w_ptr_dec;
                n_state = kleb_pkg::S_INS_RD;
            end
            // delete: pull the character right of the pointer one place left
            kleb_pkg::S_DEL_RD: begin
                w_raddr = w_ptr_inc[AW-1:0];
                if (w_cmp_lt) begin
                    n_state = kleb_pkg::S_DEL_WR;
                end else begin
                    n_cursor = r_cursor - ONE;
                    n_len    = r_len - ONE;
                    n_state  = kleb_pkg::S_RESP;
                end
            end
            kleb_pkg::S_DEL_WR: begin
                w_we    = 1'b1;
                n_ptr   = w_ptr_inc;
                n_state = kleb_pkg::S_DEL_RD;
            end
            kleb_pkg::S_READ: begin
                n_rd    = r_rdata;
                n_state = kleb_pkg::S_RESP;
            end
            // hand the result over once the output register is free
            kleb_pkg::S_RESP: begin
                if (!r_o_valid || !i_stall) begin
                    w_load    = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = kleb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kleb_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kleb_pkg::S_IDLE;
            r_esc     <= kleb_pkg::ESC_NONE;
            r_len     <= '0;
            r_cursor  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_esc     <= n_esc;
            r_len     <= n_len;
            r_cursor  <= n_cursor;
            r_o_valid <= n_o_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_char  <= n_char;
        r_rd    <= n_rd;
        r_enter <= n_enter;
        r_ovf   <= n_ovf;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_read_char       <= r_rd;
            o_text_length     <= w_len_out[8:0];
            o_cursor_position <= w_cur_out[8:0];
            o_enter_seen      <= r_enter;
            o_overflow        <= r_ovf;
        end
    end

    // text memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

endmodule

// ===== test/kleb_line_checker.sv =====
`timescale 1ns / 100ps
// kleb_line_checker: watches both channels of keystroke_line_edit_buffer_unit, keeps its own
// copy of the line buffer, cursor and escape progress, and compares every result transaction
// depends on kleb_pkg

module kleb_line_checker
    import kleb_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_key_byte,
    input  logic [7:0] i_read_index,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_read_char,
    input  logic [8:0] i_text_length,
    input  logic [8:0] i_cursor_position,
    input  logic       i_enter_seen,
    input  logic       i_overflow,
    output int         o_fail_count,
    output int         o_pending_count
);

    // one result transaction at the block's widths
    typedef struct packed {
        logic [7:0] read_char;
        logic [8:0] text_length;
        logic [8:0] cursor;
        logic       enter;
        logic       overflow;
    } t_edit_result;

    // shadow of the line buffer
    logic [7:0]   text_mem [DEPTH];
    int           held_len;
    int           cursor_pos;
    t_esc         esc_state;
    t_edit_result expected_lines [$];
    int           mismatches;

    // insert at the cursor, later text moves right; 1 when the buffer is full
    function automatic logic insert_char(input logic [7:0] ch);
        if (held_len >= DEPTH) return 1'b1;
        for (int i = held_len; i > cursor_pos; i--) text_mem[i] = text_mem[i - 1];
        text_mem[cursor_pos] = ch;
        cursor_pos++;
        held_len++;
        return 1'b0;
    endfunction

    // remove the character before the cursor, later text moves left
    function automatic void delete_char();
        if (cursor_pos == 0) return;
        for (int i = cursor_pos - 1; i + 1 < held_len; i++) text_mem[i] = text_mem[i + 1];
        cursor_pos--;
        held_len--;
    endfunction

    // apply one input transaction to the shadow state, return the expected result
    function automatic t_edit_result apply_edit(input logic [1:0] op, input logic [7:0] key,
                                                input logic [7:0] idx);
        t_edit_result r;
        r = '0;
        case (op)
            OP_KEY: begin
                case (esc_state)
                    ESC_SEEN: begin
                        esc_state = (key == KEY_LBRACKET) ? ESC_BRACKET : ESC_NONE;
                    end
                    ESC_BRACKET: begin
                        if (key == KEY_UP_D) begin
                            if (cursor_pos > 0) cursor_pos--;
                        end else if (key == KEY_UP_C) begin
                            if (cursor_pos < held_len) cursor_pos++;
                        end
                        esc_state = ESC_NONE;
                    end
                    default: begin
                        esc_state = ESC_NONE;
                        if (key == KEY_TAB) r.overflow = insert_char(KEY_LF);
                        else if (key == KEY_LF || key == KEY_CR) r.enter = 1'b1;
                        else if (key == KEY_ESC) esc_state = ESC_SEEN;
                        else if (key == KEY_BS || key == KEY_DEL) delete_char();
                        else if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI)
                            r.overflow = insert_char(key);
                    end
                endcase
            end
            OP_READ: begin
                if (int'(idx) < held_len) r.read_char = text_mem[idx];
            end
            OP_CLEAR: begin
                held_len   = 0;
                cursor_pos = 0;
                esc_state  = ESC_NONE;
            end
            default: ;
        endcase
        r.text_length = 9'(held_len);
        r.cursor      = 9'(cursor_pos);
        return r;
    endfunction

    // first ten failures are printed, the rest only counted
    task automatic log_failure(input string msg);
        if (mismatches < 10) $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            log_failure($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // compare accepted results, then predict from accepted inputs
    always @(posedge i_clk) begin : watch
        t_edit_result want;
        if (!i_rst_n) begin
            held_len   = 0;
            cursor_pos = 0;
            esc_state  = ESC_NONE;
            expected_lines.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_lines.size() == 0) begin
                    log_failure("result transaction with nothing expected");
                end else begin
                    want = expected_lines.pop_front();
                    check_field("read_char", want.read_char, i_read_char);
                    check_field("text_length", want.text_length, i_text_length);
                    check_field("cursor_position", want.cursor, i_cursor_position);
                    check_field("enter_seen", want.enter, i_enter_seen);
                    check_field("overflow", want.overflow, i_overflow);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_lines.push_back(apply_edit(i_op, i_key_byte, i_read_index));
        end
        o_pending_count <= expected_lines.size();
        o_fail_count    <= mismatches;
    end

endmodule

// ===== test/keystroke_line_edit_buffer_unit_tb.sv =====
`timescale 1ns / 100ps
// keystroke_line_edit_buffer_unit_tb: directed and random key transactions for the line edit
// buffer, checked by kleb_line_checker; depends on kleb_pkg and the block's rtl

module keystroke_line_edit_buffer_unit_tb;

    import kleb_pkg::*;

    localparam int         DEPTH       = 256;
    localparam int         ITEM_TARGET = 1950;
    localparam int         QUIET_LIMIT = 20000;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_op         = OP_KEY;
    logic [7:0] i_key_byte   = '0;
    logic [7:0] i_read_index = '0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_read_char;
    logic [8:0] o_text_length;
    logic [8:0] o_cursor_position;
    logic       o_enter_seen;
    logic       o_overflow;

    int fail_count;
    int pending_count;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int sent_count   = 0;
    int quiet_cycles = 0;

    keystroke_line_edit_buffer_unit #(.BUFFER_DEPTH(DEPTH)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_key_byte       (i_key_byte),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_char      (o_read_char),
        .o_text_length    (o_text_length),
        .o_cursor_position(o_cursor_position),
        .o_enter_seen     (o_enter_seen),
        .o_overflow       (o_overflow)
    );

    kleb_line_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_op             (i_op),
        .i_key_byte       (i_key_byte),
        .i_read_index     (i_read_index),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_read_char      (o_read_char),
        .i_text_length    (o_text_length),
        .i_cursor_position(o_cursor_position),
        .i_enter_seen     (o_enter_seen),
        .i_overflow       (o_overflow),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // idling pattern of both sides
    task automatic set_phase(input int phase);
        case (phase)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 71;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 71;
            end
            default: begin
                idle_pct  = 10;
                stall_pct = 10;
            end
        endcase
    endtask

    // one input transaction, with optional sender gap before it
    task automatic send_txn(input logic [1:0] op, input logic [7:0] key, input logic [7:0] idx);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_key_byte   <= key;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    task automatic send_key(input logic [7:0] key);
        send_txn(OP_KEY, key, 8'($urandom_range(255)));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_txn(OP_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic send_clear();
        send_txn(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // esc '[' followed by a direction byte
    task automatic send_arrow(input logic [7:0] dir);
        send_key(KEY_ESC);
        send_key(KEY_LBRACKET);
        send_key(dir);
    endtask

    // fill from empty past capacity, with a few cursor moves, then read back
    task automatic fill_to_overflow();
        send_clear();
        for (int n = 0; n < DEPTH + 6; n++) begin
            if ($urandom_range(19) == 0) send_arrow(KEY_UP_D);
            send_key((n >= DEPTH + 3) ? KEY_TAB
                                      : 8'($urandom_range(KEY_PRINT_HI, KEY_PRINT_LO)));
        end
        repeat (6) send_read(8'($urandom_range(255)));
        send_arrow(KEY_UP_C);
        send_arrow(KEY_UP_C);
        send_read(8'(DEPTH - 1));
    endtask

    // one random edit: mostly well formed keys and sequences, some noise
    task automatic random_edit();
        int         pick;
        logic [7:0] third;
        pick = $urandom_range(99);
        if (pick < 38) begin
            send_key(8'($urandom_range(KEY_PRINT_HI, KEY_PRINT_LO)));
        end else if (pick < 44) begin
            send_key(KEY_TAB);
        end else if (pick < 54) begin
            send_key($urandom_range(1) ? KEY_BS : KEY_DEL);
        end else if (pick < 70) begin
            // arrow sequence, sometimes broken or interleaved
            third = $urandom_range(1) ? KEY_UP_D : KEY_UP_C;
            if ($urandom_range(9) == 0) third = 8'($urandom_range(255));
            send_key(KEY_ESC);
            if ($urandom_range(9) == 0) send_read(8'($urandom_range(31)));
            send_key(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : KEY_LBRACKET);
            send_key(third);
        end else if (pick < 82) begin
            send_read($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255)));
        end else if (pick < 85) begin
            send_key($urandom_range(1) ? KEY_CR : KEY_LF);
        end else if (pick < 87) begin
            send_clear();
        end else if (pick < 89) begin
            send_txn(OP_SPARE, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end else begin
            send_key(8'($urandom_range(255)));
        end
    endtask

    initial begin
        set_phase(0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // printable edges, tab, ignored bytes
        send_key(8'd65);
        send_key(KEY_PRINT_LO);
        send_key(KEY_PRINT_HI);
        send_key(KEY_TAB);
        send_key(8'd31);
        send_key(8'd0);
        send_key(8'd128);
        send_key(8'd255);
        // cursor moves and insert in the middle
        send_arrow(KEY_UP_D);
        send_arrow(KEY_UP_D);
        send_key(8'd66);
        send_arrow(KEY_UP_C);
        send_arrow(KEY_UP_C);
        send_arrow(KEY_UP_C);
        send_arrow(KEY_UP_D);
        send_key(KEY_BS);
        send_key(KEY_DEL);
        // broken escape sequences
        send_key(KEY_ESC);
        send_key(8'd81);
        send_key(KEY_ESC);
        send_key(KEY_LBRACKET);
        send_key(8'd90);
        send_key(KEY_ESC);
        send_key(KEY_CR);
        // read while an escape is pending
        send_key(KEY_ESC);
        send_read(8'd0);
        send_key(KEY_LBRACKET);
        send_key(KEY_UP_D);
        // clear drops a pending escape
        send_key(KEY_ESC);
        send_clear();
        send_key(KEY_UP_D);
        send_key(KEY_LF);
        send_key(KEY_CR);
        send_read(8'd0);
        send_read(8'd255);
        send_txn(OP_SPARE, 8'd255, 8'd255);
        // edges of an empty line
        send_clear();
        send_key(KEY_BS);
        send_arrow(KEY_UP_D);
        send_arrow(KEY_UP_C);
        send_read(8'd0);
        // full buffer
        fill_to_overflow();
        send_clear();

        // random part in two halves with a fill between
        for (int round = 1; round <= 2; round++) begin
            while (sent_count < ITEM_TARGET * round / 2) begin
                set_phase((sent_count / 128) % 4);
                random_edit();
            end
            if (round == 1) fill_to_overflow();
        end

        // drain
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== keystroke_line_edit_buffer_unit.f =====
design/kleb_pkg.sv
design/kleb_key_decode.sv
design/keystroke_line_edit_buffer_unit.sv
test/kleb_line_checker.sv
test/keystroke_line_edit_buffer_unit_tb.sv
